FILE: sv/hdt_pkg.sv
// Shared types and constants of the header dynamic table.
// Holds the entry record, the operation codes and the sequencer states.
// No dependencies; every other file of the block imports it.
package hdt_pkg;

   // One dynamic entry: handles and lengths of its name and value strings.
   typedef struct packed {
      logic [15:0] name_ref;
      logic [15:0] name_len;
      logic [15:0] value_ref;
      logic [15:0] value_len;
   } entry_type;

   // Operation selector carried by an input beat.
   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_RESIZE = 2'd1,
      FN_LOOKUP = 2'd2,
      FN_SPARE  = 2'd3
   } func_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EV_CHECK,
      ST_EV_WAIT,
      ST_EV_APPLY,
      ST_ADD,
      ST_LK_WAIT,
      ST_LK_TAKE,
      ST_RESPOND
   } state_type;

   // Fixed per-entry overhead in bytes.
   localparam logic [17:0] ENTRY_COST  = 18'd32;
   // Last static index and first dynamic index.
   localparam logic [7:0]  STATIC_LAST = 8'd61;
   localparam logic [7:0]  DYN_FIRST   = 8'd62;
   // Byte limit after reset.
   localparam logic [15:0] LIMIT_RESET = 16'd4096;

endpackage

FILE: sv/hdt_cell.sv
// One cell of the entry chain: stores a single entry and passes it on.
// On a shift it takes its neighbour's entry; it also drives its entry onto
// the read bus when the read position matches its own. Depends on hdt_pkg.
module hdt_cell #(
   parameter int POS_W = 7,
   parameter int POS   = 0
) (
   input  logic               clock,
   input  logic               shift_en,
   input  hdt_pkg::entry_type shift_in,
   input  logic [POS_W-1:0]   rd_pos,
   output hdt_pkg::entry_type entry_out,
   output hdt_pkg::entry_type rd_out
);
   import hdt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // take the neighbour's entry on a shift, else hold
   always_comb begin
      entry_in = shift_en ? shift_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

   // gated onto the read bus only at our own position
   assign rd_out = (rd_pos == POS_W'(POS)) ? entry_ff : '0;

endmodule

FILE: sv/hdt_row.sv
// Row of entry cells, newest at position 0, with a two-level registered
// read tree; read data passes the group registers and then the output register.
// Depends on hdt_pkg and hdt_cell.
module hdt_row #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     shift_en,
   input  hdt_pkg::entry_type       shift_in,
   input  logic [$clog2(DEPTH)-1:0] rd_pos,
   output hdt_pkg::entry_type       rd_entry
);
   import hdt_pkg::*;

   localparam int POS_W = $clog2(DEPTH);
   localparam int GROUP = 32;
   localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
   localparam int SLOTS = NGRP * GROUP;

   entry_type chain_w [DEPTH];
   entry_type gated_w [SLOTS];
   entry_type grp_ff  [NGRP];
   entry_type grp_in  [NGRP];
   entry_type rd_ff;
   entry_type rd_in;

   // the chain itself: each cell fed by its neighbour, cell 0 by the new entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      hdt_cell #(
         .POS_W (POS_W),
         .POS   (i)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .shift_in  ((i == 0) ? shift_in : chain_w[(i == 0) ? 0 : i - 1]),
         .rd_pos    (rd_pos),
         .entry_out (chain_w[i]),
         .rd_out    (gated_w[i])
      );
   end

   // padding slots of a partial last group
   for (genvar j = DEPTH; j < SLOTS; j++) begin : g_pad
      assign gated_w[j] = '0;
   end

   // first level: OR within each group of cells
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            grp_in[g] = grp_in[g] | gated_w[g * GROUP + k];
         end
      end
   end

   // second level: OR across groups
   always_comb begin
      rd_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_in = rd_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
      rd_ff <= rd_in;
   end

   assign rd_entry = rd_ff;

endmodule

FILE: sv/header_dynamic_table.sv
// Header dynamic table: top level with the operation sequencer.
// Depends on hdt_pkg and hdt_row (which holds the hdt_cell chain).
//
// Usage
//   req_*  : input beats (valid/stall). func selects add, resize or lookup.
//   rsp_*  : one result beat per input beat (valid/stall), in order.
//   csr_*  : write of the byte limit (valid/ready); also evicts down to it.
// Steps (from the accepting edge to the edge that loads the result)
//   Dynamic lookup: wait and take steps for the read tree, then respond.
//   Add: check, add step, respond; resize: check, respond; each plus a wait
//   and an apply step per evicted oldest entry, as every eviction reads the
//   oldest cell's lengths through the tree. Static or missing lookup, oversized
//   add, unused code: respond at once. Limit write: check and evictions, no
//   result beat. One item at a time; the next is taken once back in idle.
// Reset
//   Synchronous: empties the table, limit 4096, no result pending.
// Stall
//   The result register holds the last beat; a new item is accepted while
//   it waits, and is held in its final step until the register frees.
module header_dynamic_table #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_name_handle,
   input  logic [15:0] req_name_length,
   input  logic [15:0] req_value_handle,
   input  logic [15:0] req_value_length,
   input  logic [15:0] req_new_max_bytes,
   input  logic [7:0]  req_entry_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic        rsp_from_static,
   output logic [5:0]  rsp_static_entry,
   output logic [15:0] rsp_found_name_handle,
   output logic [15:0] rsp_found_name_length,
   output logic [15:0] rsp_found_value_handle,
   output logic [15:0] rsp_found_value_length,
   output logic [15:0] rsp_used_bytes,
   output logic [7:0]  rsp_entry_count,
   // limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_initial_max_bytes
);
   import hdt_pkg::*;

   localparam int POS_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = CNT_W + 8;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [16:0]      bytes_ff, bytes_in;
   logic [15:0]      limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item context
   func_type         op_ff, op_in;
   logic             csr_op_ff, csr_op_in;
   logic             ok_ff, ok_in;
   logic             stat_ff, stat_in;
   logic [17:0]      cost_ff, cost_in;
   entry_type        ent_ff, ent_in;
   logic [7:0]       idx_ff, idx_in;
   entry_type        found_ff, found_in;

   // result register
   logic             rsp_ok_ff;
   logic             rsp_stat_ff;
   logic [5:0]       rsp_sent_ff;
   entry_type        rsp_found_ff;
   logic [15:0]      rsp_bytes_ff;
   logic [7:0]       rsp_count_ff;

   logic             shift_en;
   logic             rsp_load;
   logic             out_free;
   logic [POS_W-1:0] rd_pos;
   entry_type        rd_entry;
   logic [17:0]      new_cost;
   logic [7:0]       lk_off;
   logic             static_hit;
   logic             dyn_hit;
   logic [18:0]      add_sum;
   logic [17:0]      ev_cost;
   logic             need_evict;

   // entry chain
   hdt_row #(
      .DEPTH (TABLE_DEPTH)
   ) u_row (
      .clock    (clock),
      .shift_en (shift_en),
      .shift_in (ent_ff),
      .rd_pos   (rd_pos),
      .rd_entry (rd_entry)
   );

   // handshakes
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // decode of the incoming beat
   assign new_cost   = 18'(req_name_length) + 18'(req_value_length) + ENTRY_COST;
   assign lk_off     = req_entry_index - DYN_FIRST;
   assign static_hit = (req_entry_index != 8'd0) && (req_entry_index <= STATIC_LAST);
   assign dyn_hit    = (req_entry_index >= DYN_FIRST) &&
                       (CMP_W'(lk_off) < CMP_W'(held_ff));

   // read position: lookup offset while idle, oldest entry otherwise
   assign rd_pos = (state_ff == ST_IDLE) ? POS_W'(lk_off)
                                         : POS_W'(held_ff - CNT_W'(1));

   // eviction arithmetic
   assign add_sum = 19'(bytes_ff) + 19'(cost_ff);
   assign ev_cost = 18'(rd_entry.name_len) + 18'(rd_entry.value_len) + ENTRY_COST;
   assign need_evict = (op_ff == FN_ADD)
                     ? ((held_ff != '0) &&
                        ((add_sum > 19'(limit_ff)) || (held_ff == CNT_W'(TABLE_DEPTH))))
                     : (bytes_ff > 17'(limit_ff));

   // sequencer: next state and datapath controls
   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      bytes_in  = bytes_ff;
      limit_in  = limit_ff;
      op_in     = op_ff;
      csr_op_in = csr_op_ff;
      ok_in     = ok_ff;
      stat_in   = stat_ff;
      cost_in   = cost_ff;
      ent_in    = ent_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      shift_en  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               limit_in  = csr_initial_max_bytes;
               op_in     = FN_RESIZE;
               csr_op_in = 1'b1;
               state_in  = ST_EV_CHECK;
            end else if (req_valid) begin
               op_in     = func_type'(req_func);
               csr_op_in = 1'b0;
               ent_in    = '{name_ref:  req_name_handle,
                             name_len:  req_name_length,
                             value_ref: req_value_handle,
                             value_len: req_value_length};
               idx_in    = req_entry_index;
               cost_in   = new_cost;
               ok_in     = 1'b0;
               stat_in   = 1'b0;
               found_in  = '0;
               case (func_type'(req_func))
                  FN_ADD: begin
                     // oversized entry empties the table
                     if (new_cost > 18'(limit_ff)) begin
                        held_in  = '0;
                        bytes_in = '0;
                        state_in = ST_RESPOND;
                     end else begin
                        state_in = ST_EV_CHECK;
                     end
                  end
                  FN_RESIZE: begin
                     limit_in = req_new_max_bytes;
                     ok_in    = 1'b1;
                     state_in = ST_EV_CHECK;
                  end
                  FN_LOOKUP: begin
                     if (static_hit) begin
                        ok_in    = 1'b1;
                        stat_in  = 1'b1;
                        state_in = ST_RESPOND;
                     end else if (dyn_hit) begin
                        ok_in    = 1'b1;
                        state_in = ST_LK_WAIT;
                     end else begin
                        state_in = ST_RESPOND;
                     end
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_EV_CHECK: begin
            if (need_evict) begin
               state_in = ST_EV_WAIT;
            end else if (op_ff == FN_ADD) begin
               state_in = ST_ADD;
            end else if (csr_op_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_EV_WAIT: begin
            state_in = ST_EV_APPLY;
         end
         ST_EV_APPLY: begin
            // drop the oldest entry; an empty table always has zero bytes
            held_in = held_ff - CNT_W'(1);
            if ((held_ff == CNT_W'(1)) || (ev_cost > 18'(bytes_ff))) begin
               bytes_in = '0;
            end else begin
               bytes_in = 17'(18'(bytes_ff) - ev_cost);
            end
            state_in = ST_EV_CHECK;
         end
         ST_ADD: begin
            shift_en = 1'b1;
            held_in  = held_ff + CNT_W'(1);
            bytes_in = 17'(add_sum);
            ok_in    = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_LK_WAIT: begin
            state_in = ST_LK_TAKE;
         end
         ST_LK_TAKE: begin
            found_in = rd_entry;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         bytes_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         op_ff        <= FN_SPARE;
         csr_op_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         bytes_ff     <= bytes_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         csr_op_ff    <= csr_op_in;
      end
   end

   // item context
   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      stat_ff  <= stat_in;
      cost_ff  <= cost_in;
      ent_ff   <= ent_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_stat_ff  <= stat_ff;
         rsp_sent_ff  <= stat_ff ? idx_ff[5:0] : 6'd0;
         rsp_found_ff <= found_ff;
         rsp_bytes_ff <= bytes_ff[15:0];
         rsp_count_ff <= 8'(held_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_ok                 = rsp_ok_ff;
   assign rsp_from_static        = rsp_stat_ff;
   assign rsp_static_entry       = rsp_sent_ff;
   assign rsp_found_name_handle  = rsp_found_ff.name_ref;
   assign rsp_found_name_length  = rsp_found_ff.name_len;
   assign rsp_found_value_handle = rsp_found_ff.value_ref;
   assign rsp_found_value_length = rsp_found_ff.value_len;
   assign rsp_used_bytes         = rsp_bytes_ff;
   assign rsp_entry_count        = rsp_count_ff;

   // an empty table holds no bytes
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> (bytes_ff == '0))
      else $error("empty table with bytes in use");

   // between items the table fits its limit
   a_fits_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (bytes_ff <= 17'(limit_ff)))
      else $error("table exceeds limit while idle");

   // only an add step grows the entry count
   a_grow_on_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ADD) |=> (held_ff <= $past(held_ff)))
      else $error("entry count grew outside an add");

   // eviction never runs on an empty table
   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV_APPLY) |-> (held_ff != '0))
      else $error("eviction from an empty table");

endmodule

FILE: bench/hdt_checker.sv
// Scoreboard for the header dynamic table: watches request, result and limit-write beats.
// It keeps its own copy of the entry ring, predicts each result and compares it.
// Depends on hdt_pkg for the operation codes, the entry record and the index constants.
module hdt_checker #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_name_handle,
   input  logic [15:0] req_name_length,
   input  logic [15:0] req_value_handle,
   input  logic [15:0] req_value_length,
   input  logic [15:0] req_new_max_bytes,
   input  logic [7:0]  req_entry_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_ok,
   input  logic        rsp_from_static,
   input  logic [5:0]  rsp_static_entry,
   input  logic [15:0] rsp_found_name_handle,
   input  logic [15:0] rsp_found_name_length,
   input  logic [15:0] rsp_found_value_handle,
   input  logic [15:0] rsp_found_value_length,
   input  logic [15:0] rsp_used_bytes,
   input  logic [7:0]  rsp_entry_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_initial_max_bytes,
   output int          fault_count,
   output int          results_due,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import hdt_pkg::*;

   // One result beat as the table reports it
   typedef struct packed {
      logic        ok;
      logic        from_static;
      logic [5:0]  static_entry;
      logic [15:0] name_handle;
      logic [15:0] name_length;
      logic [15:0] value_handle;
      logic [15:0] value_length;
      logic [15:0] used_bytes;
      logic [7:0]  entry_count;
   } table_reply_type;

   // Shadow of the table: ring of entries, newest slot, count, bytes and limit
   entry_type       ring [TABLE_DEPTH];
   int unsigned     newest;
   int unsigned     held;
   int unsigned     used;
   int unsigned     byte_limit;
   table_reply_type replies_due [$];

   function automatic void clear_table();
      newest     = 0;
      held       = 0;
      used       = 0;
      byte_limit = 32'(LIMIT_RESET);
   endfunction

   // Ring slot of the entry 'age' adds back from the newest
   function automatic int unsigned slot_at(int unsigned age);
      return (newest + TABLE_DEPTH - (age % TABLE_DEPTH)) % TABLE_DEPTH;
   endfunction

   function automatic void drop_oldest();
      int unsigned s;
      int unsigned cost;
      if (held == 0) begin
         used = 0;
         return;
      end
      s    = slot_at(held - 1);
      cost = 32'(ring[s].name_len) + 32'(ring[s].value_len) + 32'(ENTRY_COST);
      held--;
      used = (cost > used) ? 0 : used - cost;
      if (held == 0)
         used = 0;
   endfunction

   // Evict oldest entries until the bytes fit, then take the new limit
   function automatic void trim_to(int unsigned lim);
      while (used > lim)
         drop_oldest();
      byte_limit = lim;
   endfunction

   // Apply one request beat to the shadow table and return its result
   function automatic table_reply_type apply_op(func_type f, logic [15:0] nh, logic [15:0] nl,
                                                logic [15:0] vh, logic [15:0] vl,
                                                logic [15:0] nmax, logic [7:0] idx);
      table_reply_type r;
      int unsigned     cost;
      int unsigned     s;
      r = '0;
      case (f)
         FN_ADD: begin
            cost = 32'(nl) + 32'(vl) + 32'(ENTRY_COST);
            if (cost > byte_limit) begin
               // oversized entry empties the table and is not stored
               held = 0;
               used = 0;
            end else begin
               while (held > 0 && (used + cost > byte_limit || held >= TABLE_DEPTH))
                  drop_oldest();
               newest = (newest + 1) % TABLE_DEPTH;
               ring[newest] = '{name_ref: nh, name_len: nl, value_ref: vh, value_len: vl};
               held++;
               used += cost;
               r.ok = 1'b1;
            end
         end
         FN_RESIZE: begin
            trim_to(32'(nmax));
            r.ok = 1'b1;
         end
         FN_LOOKUP: begin
            if (idx >= 8'd1 && idx <= STATIC_LAST) begin
               r.ok           = 1'b1;
               r.from_static  = 1'b1;
               r.static_entry = idx[5:0];
            end else if (idx >= DYN_FIRST && 32'(idx - DYN_FIRST) < held) begin
               s              = slot_at(32'(idx - DYN_FIRST));
               r.ok           = 1'b1;
               r.name_handle  = ring[s].name_ref;
               r.name_length  = ring[s].name_len;
               r.value_handle = ring[s].value_ref;
               r.value_length = ring[s].value_len;
            end
         end
         default: ;
      endcase
      r.used_bytes  = 16'(used);
      r.entry_count = 8'(held);
      return r;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         fault_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Beats are taken at the rising edge; results first, as they belong to older requests
   always @(posedge clock) begin : watch
      table_reply_type want;
      table_reply_type got;
      if (reset) begin
         clear_table();
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.ok           = rsp_ok;
            got.from_static  = rsp_from_static;
            got.static_entry = rsp_static_entry;
            got.name_handle  = rsp_found_name_handle;
            got.name_length  = rsp_found_name_length;
            got.value_handle = rsp_found_value_handle;
            got.value_length = rsp_found_value_length;
            got.used_bytes   = rsp_used_bytes;
            got.entry_count  = rsp_entry_count;
            if (replies_due.size() == 0) begin
               fault_count++;
               $display("%0t ns: result beat expected none, got ok %0d used %0d count %0d",
                        $time, got.ok, got.used_bytes, got.entry_count);
            end else begin
               want = replies_due.pop_front();
               compare_field("ok", 32'(want.ok), 32'(got.ok));
               compare_field("from_static", 32'(want.from_static), 32'(got.from_static));
               compare_field("static_entry", 32'(want.static_entry),
                             32'(got.static_entry));
               compare_field("found_name_handle", 32'(want.name_handle),
                             32'(got.name_handle));
               compare_field("found_name_length", 32'(want.name_length),
                             32'(got.name_length));
               compare_field("found_value_handle", 32'(want.value_handle),
                             32'(got.value_handle));
               compare_field("found_value_length", 32'(want.value_length),
                             32'(got.value_length));
               compare_field("used_bytes", 32'(want.used_bytes), 32'(got.used_bytes));
               compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
               results_checked++;
            end
         end
         // limit write behaves as a resize
         if (csr_valid && csr_ready)
            trim_to(32'(csr_initial_max_bytes));
         if (req_valid && !req_stall)
            replies_due.push_back(apply_op(func_type'(req_func), req_name_handle,
                                           req_name_length, req_value_handle,
                                           req_value_length, req_new_max_bytes,
                                           req_entry_index));
      end
      results_due = replies_due.size();
   end

endmodule

FILE: bench/tb.sv
// Top of the header dynamic table bench: clock, reset, stimulus and the verdict.
// Instantiates header_dynamic_table as dut and hdt_checker beside it.
// Depends on hdt_pkg, header_dynamic_table and hdt_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hdt_pkg::*;

   // One request beat before it is put on the pins
   typedef struct {
      func_type    func;
      logic [15:0] name_handle;
      logic [15:0] name_length;
      logic [15:0] value_handle;
      logic [15:0] value_length;
      logic [15:0] new_max;
      logic [7:0]  index;
   } table_op_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [15:0] req_name_handle;
   logic [15:0] req_name_length;
   logic [15:0] req_value_handle;
   logic [15:0] req_value_length;
   logic [15:0] req_new_max_bytes;
   logic [7:0]  req_entry_index;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic        rsp_from_static;
   logic [5:0]  rsp_static_entry;
   logic [15:0] rsp_found_name_handle;
   logic [15:0] rsp_found_name_length;
   logic [15:0] rsp_found_value_handle;
   logic [15:0] rsp_found_value_length;
   logic [15:0] rsp_used_bytes;
   logic [7:0]  rsp_entry_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_initial_max_bytes;

   int          fault_count;
   int          results_due;
   int          results_checked;

   int          gap_pct   = 0;
   int          stall_pct = 0;
   int unsigned sent_by_func [4];
   int unsigned limit_writes = 0;

   header_dynamic_table dut (.*);
   hdt_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Put one beat on the request pins and hold it until taken
   task automatic drive_op(input table_op_type o);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_func          <= o.func;
      req_name_handle   <= o.name_handle;
      req_name_length   <= o.name_length;
      req_value_handle  <= o.value_handle;
      req_value_length  <= o.value_length;
      req_new_max_bytes <= o.new_max;
      req_entry_index   <= o.index;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_by_func[o.func]++;
   endtask

   // Fields an operation ignores carry random values
   function automatic table_op_type noise_op(func_type f);
      table_op_type o;
      o.func         = f;
      o.name_handle  = 16'($urandom);
      o.name_length  = 16'($urandom);
      o.value_handle = 16'($urandom);
      o.value_length = 16'($urandom);
      o.new_max      = 16'($urandom);
      o.index        = 8'($urandom);
      return o;
   endfunction

   task automatic send_add(input logic [15:0] nh, input logic [15:0] nl,
                           input logic [15:0] vh, input logic [15:0] vl);
      table_op_type o;
      o              = noise_op(FN_ADD);
      o.name_handle  = nh;
      o.name_length  = nl;
      o.value_handle = vh;
      o.value_length = vl;
      drive_op(o);
   endtask

   task automatic send_resize(input logic [15:0] m);
      table_op_type o;
      o         = noise_op(FN_RESIZE);
      o.new_max = m;
      drive_op(o);
   endtask

   task automatic send_lookup(input logic [7:0] i);
      table_op_type o;
      o       = noise_op(FN_LOOKUP);
      o.index = i;
      drive_op(o);
   endtask

   // Drain the table, then write the limit register
   task automatic write_limit(input logic [15:0] lim);
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_initial_max_bytes <= lim;
      csr_valid             <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   // One random beat, shaped around the limit of the phase
   task automatic random_op(input int unsigned lim);
      int unsigned pick;
      int unsigned cap;
      logic [15:0] nl;
      logic [15:0] vl;
      logic [15:0] m;
      logic [7:0]  i;
      pick = $urandom_range(99);
      cap  = lim / 6;
      if (pick < 45) begin
         if ($urandom_range(99) < 12) begin
            nl = 16'($urandom);
            vl = 16'($urandom);
         end else begin
            nl = 16'($urandom_range(0, cap));
            vl = 16'($urandom_range(0, cap));
         end
         send_add(16'($urandom), nl, 16'($urandom), vl);
      end else if (pick < 85) begin
         pick = $urandom_range(99);
         if (pick < 50)      i = 8'($urandom_range(62, 75));
         else if (pick < 75) i = 8'($urandom_range(62, 189));
         else if (pick < 88) i = 8'($urandom_range(1, 61));
         else                i = 8'($urandom_range(0, 255));
         send_lookup(i);
      end else if (pick < 95) begin
         pick = $urandom_range(99);
         if (pick < 40)      m = 16'(lim);
         else if (pick < 70) m = 16'($urandom_range(lim / 2, lim));
         else if (pick < 85) m = 16'($urandom);
         else                m = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         send_resize(m);
      end else begin
         drive_op(noise_op(FN_SPARE));
      end
   endtask

   initial begin
      int unsigned phase_limit [8];
      int unsigned fill_len;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_func              = FN_ADD;
      req_name_handle       = '0;
      req_name_length       = '0;
      req_value_handle      = '0;
      req_value_length      = '0;
      req_new_max_bytes     = '0;
      req_entry_index       = '0;
      csr_valid             = 1'b0;
      csr_initial_max_bytes = '0;
      phase_limit = '{4096, 65535, 0, 200, $urandom_range(0, 65535), 65535, 1000,
                      $urandom_range(0, 65535)};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: static and dynamic index edges, exact and oversized entries, resizes
      write_limit(16'd4096);
      send_lookup(8'd0);
      send_lookup(8'd1);
      send_lookup(8'd61);
      send_lookup(8'd62);
      send_add(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      send_add(16'h0000, 16'd10, 16'h0001, 16'd20);
      send_lookup(8'd62);
      send_lookup(8'd63);
      send_lookup(8'd64);
      send_lookup(8'd255);
      drive_op(noise_op(FN_SPARE));
      send_add(16'h1234, 16'd2032, 16'h5678, 16'd2032);   // costs the limit exactly
      send_add(16'hAAAA, 16'd2032, 16'h5555, 16'd2033);   // one byte over: table emptied
      send_add(16'h0000, 16'd0, 16'h0000, 16'd0);
      send_add(16'h0001, 16'd0, 16'h0002, 16'd0);
      send_resize(16'd40);
      send_lookup(8'd62);
      send_add(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_resize(16'd0);
      send_resize(16'hFFFF);
      send_add(16'h0007, 16'hFFFF, 16'h0008, 16'd0);       // 32 over the top limit
      send_add(16'h0009, 16'd65503, 16'h000A, 16'd0);      // fills the top limit
      send_lookup(8'd62);
      send_resize(16'd4096);

      // Random phases: each with its own limit and idling pattern
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 48; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 48; end
            default: begin gap_pct = 13; stall_pct = 13; end
         endcase
         write_limit(16'(phase_limit[p]));
         // small entries past the slot count, so the ring wraps and evicts on depth
         if (phase_limit[p] >= 4096) begin
            fill_len = (phase_limit[p] / 128 - 32) / 2;
            repeat (140)
               send_add(16'($urandom), 16'($urandom_range(0, fill_len)),
                        16'($urandom), 16'($urandom_range(0, fill_len)));
         end
         repeat (220)
            random_op(phase_limit[p]);
      end
      req_valid <= 1'b0;

      // Drain, then let stray beats show up
      while (results_due != 0) @(negedge clock);
      repeat (400) @(negedge clock);

      $display("Sent %0d adds, %0d resizes, %0d lookups, %0d unused-code beats; %0d limit writes.",
               sent_by_func[FN_ADD], sent_by_func[FN_RESIZE], sent_by_func[FN_LOOKUP],
               sent_by_func[FN_SPARE], limit_writes);
      $display("Compared %0d result beats over limits from 0 to 65535.", results_checked);
      if (fault_count == 0)
         $display("header_dynamic_table: match");
      else
         $display("header_dynamic_table: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("header_dynamic_table: mismatch");
      $finish;
   end

endmodule

FILE: header_dynamic_table.f
sv/hdt_pkg.sv
sv/hdt_cell.sv
sv/hdt_row.sv
sv/header_dynamic_table.sv
bench/hdt_checker.sv
bench/tb.sv
